[src/event_flag_group_unit_macros.svh]
// Assertion helpers for the RTL.
`ifndef EVENT_FLAG_GROUP_UNIT_MACROS_SVH
`define EVENT_FLAG_GROUP_UNIT_MACROS_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define EFG_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define EFG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[src/efg_pkg.sv]
package efg_pkg;

    localparam int GROUPS  = 8;
    localparam int GRP_W   = 3;
    localparam int FLAG_W  = 32;
    localparam int TASK_W  = 6;
    localparam int CNT_W   = 16;
    localparam int MODE_W  = 3;
    localparam int STAT_W  = 3;

    localparam logic [MODE_W-1:0] MODE_CREATE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DESTROY = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SET     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_WAIT    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_TICK    = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_INVALID = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_FREE = 3'd2;
    localparam logic [STAT_W-1:0] ST_TIMEOUT = 3'd3;
    localparam logic [STAT_W-1:0] ST_PENDING = 3'd4;

    // one group's stored state
    typedef struct packed {
        logic              used;
        logic [FLAG_W-1:0] flags;
        logic              wvalid;
        logic [TASK_W-1:0] wtask;
        logic [FLAG_W-1:0] wmask;
        logic              wall;
        logic [CNT_W-1:0]  wcount;
        logic              wnolim;
        logic              wclear;
    } grp_entry_t;

    // latched input word
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [GRP_W-1:0]  grp;
        logic [FLAG_W-1:0] bits;
        logic              all;
        logic              aclr;
        logic [CNT_W-1:0]  tmo;
        logic              nolim;
        logic [TASK_W-1:0] task_id;
    } cmd_t;

    // one result word, without last
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [GRP_W-1:0]  grp;
        logic [FLAG_W-1:0] seen;
        logic              wake;
        logic [TASK_W-1:0] waiter;
    } res_t;

endpackage

[src/event_flag_group_unit.sv]
// Event-flag group pool: eight groups of 32 flags, each with at most one
// registered waiter. Commands arrive as one input word each (kind in s_tuser)
// and answer with one result word, except a tick, which answers with one
// timeout word per expiring waiter, possibly none, the final one marked by
// m_tlast. The block takes one word at a time: create, destroy, set, clear and
// wait are accepted, then make one pass through the shared group unit; a tick
// is accepted, then runs all eight groups through the same unit, one group per
// cycle unless a held-back word waits for the output slot, then flushes the
// held-back final word. A finished result sits in the output register while
// the next word is accepted. No clearing pass after reset.
module event_flag_group_unit import efg_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, from bit 0: group[2:0], flag_bits[34:3], wait_all[35],
    // clear_on_match[36], wait_ticks[52:37], wait_forever[53], task_id[59:54],
    // zero fill [63:60]
    input  logic [63:0] s_tdata,
    // s_tuser: mode[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, from bit 0: group_res[2:0], flags_seen[34:3], wake[35],
    // waiter_id[41:36], zero fill [47:42]
    output logic [47:0] m_tdata,
    // m_tuser: status[2:0]
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

`include "event_flag_group_unit_macros.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    state_t           state_reg;
    cmd_t             cmd_reg;
    logic [GRP_W-1:0] idx_reg;
    logic             pend_valid_reg;
    res_t             pend_reg;
    logic             m_valid_reg;
    res_t             m_res_reg;
    logic             m_last_reg;

    cmd_t              cmd_in;
    logic [GRP_W-1:0]  addr;
    grp_entry_t        ent_rd;
    grp_entry_t        ent_wr;
    logic [GROUPS-1:0] used_vec;
    logic [GRP_W-1:0]  free_idx;
    logic              free_ok;
    logic              alu_we;
    logic              alu_emit;
    res_t              alu_res;
    logic              slot_free;
    logic              scan_stall;
    logic              store_we;
    logic              out_load;

    // unpack the input word
    assign cmd_in.mode    = s_tuser;
    assign cmd_in.grp     = s_tdata[2:0];
    assign cmd_in.bits    = s_tdata[34:3];
    assign cmd_in.all     = s_tdata[35];
    assign cmd_in.aclr    = s_tdata[36];
    assign cmd_in.tmo     = s_tdata[52:37];
    assign cmd_in.nolim   = s_tdata[53];
    assign cmd_in.task_id = s_tdata[59:54];

    // lowest free group for create
    always_comb begin
        free_idx = '0;
        free_ok  = 1'b0;
        for (int i = GROUPS - 1; i >= 0; i--) begin
            if (!used_vec[i]) begin
                free_idx = GRP_W'(i);
                free_ok  = 1'b1;
            end
        end
    end

    always_comb begin
        if (state_reg == ST_SCAN) begin
            addr = idx_reg;
        end else if (cmd_reg.mode == MODE_CREATE) begin
            addr = free_idx;
        end else begin
            addr = cmd_reg.grp;
        end
    end

    efg_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .addr     (addr),
        .wr_en    (store_we),
        .wr_data  (ent_wr),
        .rd_data  (ent_rd),
        .used_vec (used_vec)
    );

    efg_alu u_alu (
        .cmd      (cmd_reg),
        .ent      (ent_rd),
        .ent_idx  (addr),
        .free_ok  (free_ok),
        .ent_next (ent_wr),
        .wr_en    (alu_we),
        .emit     (alu_emit),
        .res      (alu_res)
    );

    assign slot_free  = !m_valid_reg || m_tready;
    // a tick hit with a word already held back needs the output slot
    assign scan_stall = alu_emit && pend_valid_reg && !slot_free;

    // output register takes a new word this cycle
    assign out_load = ((state_reg == ST_EXEC) && slot_free) ||
                      ((state_reg == ST_SCAN) && !scan_stall && alu_emit && pend_valid_reg) ||
                      ((state_reg == ST_FLUSH) && pend_valid_reg && slot_free);

    always_comb begin
        case (state_reg)
            ST_EXEC: store_we = alu_we && slot_free;
            ST_SCAN: store_we = alu_we && !scan_stall;
            default: store_we = 1'b0;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg <= cmd_in;
                        idx_reg <= '0;
                        state_reg <= (cmd_in.mode == MODE_TICK) ? ST_SCAN : ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (slot_free) begin
                        m_res_reg   <= alu_res;
                        m_last_reg  <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                ST_SCAN: begin
                    if (!scan_stall) begin
                        if (alu_emit) begin
                            // the held word is not the last one: send it now
                            if (pend_valid_reg) begin
                                m_res_reg   <= pend_reg;
                                m_last_reg  <= 1'b0;
                            end
                            pend_valid_reg <= 1'b1;
                            pend_reg       <= alu_res;
                        end
                        if (idx_reg == GRP_W'(GROUPS - 1)) begin
                            state_reg <= ST_FLUSH;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (!pend_valid_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (slot_free) begin
                        m_res_reg      <= pend_reg;
                        m_last_reg     <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {6'd0, m_res_reg.waiter, m_res_reg.wake, m_res_reg.seen,
                       m_res_reg.grp};
    assign m_tlast  = m_last_reg;

    `EFG_ASSERT_IMPL(a_pend_in_tick, pend_valid_reg,
        (state_reg == ST_SCAN) || (state_reg == ST_FLUSH), "held word outside a tick")
    `EFG_ASSERT_NEXT(a_cmd_to_exec, s_tvalid && s_tready && (s_tuser != MODE_TICK),
        state_reg == ST_EXEC, "non-tick word did not go to exec")
    `EFG_ASSERT_IMPL(a_write_used, store_we && (cmd_reg.mode != MODE_CREATE),
        ent_rd.used, "write to a group not in use")

endmodule

[src/efg_store.sv]
module efg_store import efg_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [GRP_W-1:0] addr,
    input  logic             wr_en,
    input  grp_entry_t       wr_data,
    output grp_entry_t       rd_data,
    output logic [GROUPS-1:0] used_vec
);

    grp_entry_t ent_reg [GROUPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < GROUPS; i++) begin
                ent_reg[i] <= '0;
            end
        end else if (wr_en) begin
            ent_reg[addr] <= wr_data;
        end
    end

    assign rd_data = ent_reg[addr];

    always_comb begin
        for (int i = 0; i < GROUPS; i++) begin
            used_vec[i] = ent_reg[i].used;
        end
    end

endmodule

[src/efg_alu.sv]
// Shared per-group unit: applies one command to one group entry.
module efg_alu import efg_pkg::*; (
    input  cmd_t             cmd,
    input  grp_entry_t       ent,
    input  logic [GRP_W-1:0] ent_idx,
    input  logic             free_ok,
    output grp_entry_t       ent_next,
    output logic             wr_en,
    output logic             emit,
    output res_t             res
);

    logic [FLAG_W-1:0] set_flags;
    logic              set_hit;
    logic              wait_hit;
    logic [CNT_W-1:0]  cnt_dec;

    assign set_flags = ent.flags | cmd.bits;
    assign set_hit   = ent.wvalid && (ent.wall ? ((set_flags & ent.wmask) == ent.wmask)
                                               : ((set_flags & ent.wmask) != '0));
    assign wait_hit  = cmd.all ? ((ent.flags & cmd.bits) == cmd.bits)
                               : ((ent.flags & cmd.bits) != '0);
    assign cnt_dec   = (ent.wcount != '0) ? ent.wcount - 1'b1 : ent.wcount;

    always_comb begin
        ent_next   = ent;
        wr_en      = 1'b0;
        emit       = 1'b1;
        res        = '0;
        res.status = ST_OK;
        res.grp    = cmd.grp;
        case (cmd.mode)
            MODE_CREATE: begin
                if (!free_ok) begin
                    res.status = ST_NO_FREE;
                    res.grp    = '0;
                end else begin
                    ent_next.used   = 1'b1;
                    ent_next.flags  = '0;
                    ent_next.wvalid = 1'b0;
                    ent_next.wmask  = '0;
                    wr_en           = 1'b1;
                    res.grp         = ent_idx;
                end
            end
            MODE_TICK: begin
                emit    = 1'b0;
                res.grp = ent_idx;
                if (ent.used && ent.wvalid && !ent.wnolim) begin
                    wr_en           = 1'b1;
                    ent_next.wcount = cnt_dec;
                    if (cnt_dec == '0) begin
                        ent_next.wvalid = 1'b0;
                        emit            = 1'b1;
                        res.status      = ST_TIMEOUT;
                        res.waiter      = ent.wtask;
                    end
                end
            end
            MODE_DESTROY, MODE_SET, MODE_CLEAR, MODE_WAIT: begin
                if (!ent.used) begin
                    res.status = ST_INVALID;
                end else begin
                    case (cmd.mode)
                        MODE_DESTROY: begin
                            ent_next.used   = 1'b0;
                            ent_next.wvalid = 1'b0;
                            wr_en           = 1'b1;
                        end
                        MODE_SET: begin
                            wr_en          = 1'b1;
                            ent_next.flags = set_flags;
                            if (set_hit) begin
                                ent_next.wvalid = 1'b0;
                                if (ent.wclear) begin
                                    ent_next.flags = set_flags & ~ent.wmask;
                                end
                                res.seen   = set_flags;
                                res.wake   = 1'b1;
                                res.waiter = ent.wtask;
                            end
                        end
                        MODE_CLEAR: begin
                            wr_en          = 1'b1;
                            ent_next.flags = ent.flags & ~cmd.bits;
                        end
                        default: begin
                            if (cmd.bits == '0) begin
                                res.status = ST_INVALID;
                            end else if (wait_hit) begin
                                res.seen = ent.flags;
                                if (cmd.aclr) begin
                                    wr_en          = 1'b1;
                                    ent_next.flags = ent.flags & ~cmd.bits;
                                end
                            end else if (!cmd.nolim && cmd.tmo == '0) begin
                                res.status = ST_TIMEOUT;
                            end else begin
                                wr_en           = 1'b1;
                                ent_next.wvalid = 1'b1;
                                ent_next.wtask  = cmd.task_id;
                                ent_next.wmask  = cmd.bits;
                                ent_next.wall   = cmd.all;
                                ent_next.wclear = cmd.aclr;
                                ent_next.wcount = cmd.tmo;
                                ent_next.wnolim = cmd.nolim;
                                res.status      = ST_PENDING;
                            end
                        end
                    endcase
                end
            end
            default: begin
                res.status = ST_INVALID;
            end
        endcase
    end

endmodule
